>>> hw/rtl/str_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and CRC helper for the sequenced transfer reassembly block.
package str_pkg;

    localparam int MaxBytes     = 4096;
    localparam int PayloadBytes = 6;
    localparam int MaxFrames    = 683;

    localparam int FrameW   = $clog2(MaxFrames);
    localparam int LenW     = $clog2(MaxBytes + 1);
    localparam int ByteIdxW = $clog2(PayloadBytes);
    localparam int RowW     = 8 * PayloadBytes;

    // Reciprocal for the frame count: ceil(len / PayloadBytes) as a multiply and shift.
    localparam int RecipShift = 18;
    localparam int Recip      = ((2 ** RecipShift) + PayloadBytes - 1) / PayloadBytes;
    localparam int RecipW     = RecipShift;

    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DATA  = 2'd1,
        OP_QUERY = 2'd2,
        OP_RSV   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RES_BEG_OK  = 3'd0,
        RES_BEG_REJ = 3'd1,
        RES_STORED  = 3'd2,
        RES_IGNORED = 3'd3,
        RES_STATUS  = 3'd4
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_BEG_CLR,
        S_DAT_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_CRC_RD,
        S_CRC_BYTE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] transfer_length;
        logic [15:0] expected_check;
        logic [15:0] frame_number;
        logic [2:0]  payload_length;
        logic [47:0] payload_bytes;
    } t_in;

    typedef struct packed {
        logic [2:0] result_code;
        logic       all_received;
        logic [9:0] first_missing;
        logic       transfer_complete;
    } t_out;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic map_clr_step;
        logic cnt_clr;
        logic cnt_inc;
        logic begin_commit;
        logic map_rd_seq;
        logic map_rd_cnt;
        logic data_write;
        logic crc_init;
        logic row_rd;
        logic crc_byte;
        logic res_set;
        t_res res_code;
        logic res_found;
        logic res_all;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        t_op  opcode;
        logic clr_last;
        logic begin_ok;
        logic data_ok;
        logic active;
        logic map_q;
        logic srch_done;
        logic crc_done;
        logic row_last;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] crc_upd(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/str_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the reassembly block.
module str_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  str_pkg::t_sts     i_sts,
    output str_pkg::t_cmd     o_cmd
);

    str_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= str_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            str_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = str_pkg::S_IDLE;
            end
            str_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = str_pkg::S_DECODE;
                end
            end
            str_pkg::S_DECODE: begin
                unique case (i_sts.opcode)
                    str_pkg::OP_BEGIN: begin
                        if (i_sts.begin_ok) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state = str_pkg::S_BEG_CLR;
                        end else begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_code = str_pkg::RES_BEG_REJ;
                            n_state = str_pkg::S_DONE;
                        end
                    end
                    str_pkg::OP_DATA: begin
                        if (i_sts.data_ok) begin
                            o_cmd.map_rd_seq = 1'b1;
                            n_state = str_pkg::S_DAT_CHK;
                        end else begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_code = str_pkg::RES_IGNORED;
                            n_state = str_pkg::S_DONE;
                        end
                    end
                    str_pkg::OP_QUERY, str_pkg::OP_RSV: begin
                        if (i_sts.active) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state = str_pkg::S_SRCH_RD;
                        end else begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_code = str_pkg::RES_STATUS;
                            n_state = str_pkg::S_DONE;
                        end
                    end
                    default: n_state = str_pkg::S_IDLE;
                endcase
            end
            str_pkg::S_BEG_CLR: begin
                o_cmd.map_clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.begin_commit = 1'b1;
                    o_cmd.res_set      = 1'b1;
                    o_cmd.res_code     = str_pkg::RES_BEG_OK;
                    n_state = str_pkg::S_DONE;
                end
            end
            str_pkg::S_DAT_CHK: begin
                o_cmd.res_set = 1'b1;
                if (!i_sts.map_q) begin
                    o_cmd.data_write = 1'b1;
                    o_cmd.res_code   = str_pkg::RES_STORED;
                end else begin
                    o_cmd.res_code   = str_pkg::RES_IGNORED;
                end
                n_state = str_pkg::S_DONE;
            end
            str_pkg::S_SRCH_RD: begin
                if (i_sts.srch_done) begin
                    o_cmd.crc_init = 1'b1;
                    n_state = str_pkg::S_CRC_RD;
                end else begin
                    o_cmd.map_rd_cnt = 1'b1;
                    n_state = str_pkg::S_SRCH_CHK;
                end
            end
            str_pkg::S_SRCH_CHK: begin
                if (!i_sts.map_q) begin
                    o_cmd.res_set   = 1'b1;
                    o_cmd.res_code  = str_pkg::RES_STATUS;
                    o_cmd.res_found = 1'b1;
                    n_state = str_pkg::S_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = str_pkg::S_SRCH_RD;
                end
            end
            str_pkg::S_CRC_RD: begin
                if (i_sts.crc_done) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = str_pkg::RES_STATUS;
                    o_cmd.res_all  = 1'b1;
                    n_state = str_pkg::S_DONE;
                end else begin
                    o_cmd.row_rd = 1'b1;
                    n_state = str_pkg::S_CRC_BYTE;
                end
            end
            str_pkg::S_CRC_BYTE: begin
                if (i_sts.crc_done) begin
                    n_state = str_pkg::S_CRC_RD;
                end else begin
                    o_cmd.crc_byte = 1'b1;
                    if (i_sts.row_last) n_state = str_pkg::S_CRC_RD;
                end
            end
            str_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = str_pkg::S_IDLE;
                end
            end
            default: n_state = str_pkg::S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/str_dp.sv
`timescale 1ns / 1ps
// Datapath of the reassembly block: buffers, received map, counters, CRC and result register.
module str_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  str_pkg::t_in   i_in_item,
    input  logic           i_out_ready,
    input  str_pkg::t_cmd  i_cmd,
    output str_pkg::t_sts  o_sts,
    output logic           o_out_valid,
    output str_pkg::t_out  o_out_item
);

    localparam int FW = str_pkg::FrameW;
    localparam int LW = str_pkg::LenW;
    localparam int BW = str_pkg::ByteIdxW;

    logic [str_pkg::RowW-1:0] r_rows [str_pkg::MaxFrames];
    logic                     r_map  [str_pkg::MaxFrames];

    str_pkg::t_in  r_item;
    logic          r_active;
    logic [LW-1:0] r_len;
    logic [FW-1:0] r_total;
    logic [15:0]   r_check;
    logic [FW-1:0] r_cnt;
    logic          r_map_q;
    logic [str_pkg::RowW-1:0] r_row_q;
    logic [FW-1:0] r_row;
    logic [BW-1:0] r_bidx;
    logic [LW-1:0] r_byte_cnt;
    logic [31:0]   r_crc;
    str_pkg::t_out r_pend;
    str_pkg::t_out r_out;
    logic          r_out_valid;

    logic [LW:0]   len_x;
    logic [LW+str_pkg::RecipW:0] frames_prod;
    logic [FW:0]   frames;
    logic          len_ok;
    logic [FW-1:0] seq;
    logic [LW-1:0] off;
    logic [LW-1:0] remain;
    logic [2:0]    plen;
    logic [2:0]    n_bytes;
    logic [str_pkg::PayloadBytes-1:0] be;
    logic          crc_match;

    // Frame count of a begin item; only meaningful when the length is in range.
    assign len_ok      = (r_item.transfer_length != 16'd0) &&
                         (r_item.transfer_length <= 16'(str_pkg::MaxBytes));
    assign len_x       = (LW+1)'(r_item.transfer_length[LW-1:0]) +
                         (LW+1)'(str_pkg::PayloadBytes - 1);
    assign frames_prod = (LW+str_pkg::RecipW+1)'(len_x) *
                         (LW+str_pkg::RecipW+1)'(str_pkg::Recip);
    assign frames      = frames_prod[str_pkg::RecipShift +: FW+1];

    assign seq    = r_item.frame_number[FW-1:0];
    assign off    = LW'(seq * str_pkg::PayloadBytes);
    assign remain = r_len - off;
    assign plen   = (r_item.payload_length > 3'(str_pkg::PayloadBytes)) ?
                    3'(str_pkg::PayloadBytes) : r_item.payload_length;
    assign n_bytes = (LW'(plen) < remain) ? plen : remain[2:0];

    always_comb begin
        for (int k = 0; k < str_pkg::PayloadBytes; k++) begin
            be[k] = (3'(k) < n_bytes);
        end
    end

    assign crc_match = (~r_crc[15:0]) == r_check;

    assign o_sts.opcode    = str_pkg::t_op'(r_item.opcode);
    assign o_sts.clr_last  = (r_cnt == FW'(str_pkg::MaxFrames - 1));
    assign o_sts.begin_ok  = len_ok && (frames <= (FW+1)'(str_pkg::MaxFrames));
    assign o_sts.data_ok   = r_active && (r_item.frame_number < 16'(r_total));
    assign o_sts.active    = r_active;
    assign o_sts.map_q     = r_map_q;
    assign o_sts.srch_done = (r_cnt == r_total);
    assign o_sts.crc_done  = (r_byte_cnt == r_len);
    assign o_sts.row_last  = (r_bidx == BW'(str_pkg::PayloadBytes - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_len       <= '0;
            r_total     <= '0;
            r_check     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.begin_commit) begin
                r_active <= 1'b1;
                r_len    <= r_item.transfer_length[LW-1:0];
                r_total  <= frames[FW-1:0];
                r_check  <= r_item.expected_check;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.map_clr_step || i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + FW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) r_item <= i_in_item;
        if (i_cmd.crc_init) begin
            r_crc      <= str_pkg::CrcInit;
            r_byte_cnt <= '0;
            r_row      <= '0;
            r_bidx     <= '0;
        end else if (i_cmd.crc_byte) begin
            r_crc      <= str_pkg::crc_upd(r_crc, r_row_q[8*r_bidx +: 8]);
            r_byte_cnt <= r_byte_cnt + LW'(1);
            if (r_bidx == BW'(str_pkg::PayloadBytes - 1)) begin
                r_bidx <= '0;
                r_row  <= r_row + FW'(1);
            end else begin
                r_bidx <= r_bidx + BW'(1);
            end
        end
        if (i_cmd.res_set) begin
            r_pend.result_code       <= i_cmd.res_code;
            r_pend.all_received      <= i_cmd.res_all;
            r_pend.first_missing     <= i_cmd.res_found ? 10'(r_cnt) : 10'd0;
            r_pend.transfer_complete <= i_cmd.res_all && crc_match;
        end
        if (i_cmd.res_load) r_out <= r_pend;
    end

    // Received map memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || i_cmd.map_clr_step) begin
            r_map[r_cnt] <= 1'b0;
        end else if (i_cmd.data_write) begin
            r_map[seq] <= 1'b1;
        end
        if (i_cmd.map_rd_seq) begin
            r_map_q <= r_map[seq];
        end else if (i_cmd.map_rd_cnt) begin
            r_map_q <= r_map[r_cnt];
        end
    end

    // Byte buffer, one frame per row
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_rows[r_cnt] <= '0;
        end else if (i_cmd.data_write) begin
            for (int k = 0; k < str_pkg::PayloadBytes; k++) begin
                if (be[k]) r_rows[seq][8*k +: 8] <= r_item.payload_bytes[8*k +: 8];
            end
        end
        if (i_cmd.row_rd) r_row_q <= r_rows[r_row];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");
    a_write_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.data_write |-> (!r_map_q && r_active))
        else $error("duplicate or inactive frame written");
    a_crc_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.crc_byte |-> (r_byte_cnt != r_len))
        else $error("CRC ran past the transfer length");
`endif

endmodule

>>> hw/rtl/sequenced_transfer_reassembly.sv
`timescale 1ns / 1ps
// Top level of the sequenced transfer reassembly block.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes begin, data frame and
//   status query items; output channel (o_out_valid / i_out_ready / o_out_item)
//   returns exactly one result item per input item, in order.
//   Items are handled one at a time; o_in_ready is high only when the
//   sequencer is free.
// Steps per item, from input accept to result valid:
//   begin: decode, then a sweep that clears the received map one entry a
//     cycle, then the result; a rejected begin goes from decode to the result.
//   data frame: decode and map read, check and buffer write, result;
//     an out-of-range frame or one with no transfer active goes from decode to the result.
//   status query: a map read and a check per frame searched; if none is missing,
//     the CRC reads each six-byte row, then takes its bytes one byte a cycle.
// Reset: a clearing pass over all MaxFrames rows zeroes the byte buffer and the
//   received map, one row a cycle; no item is taken until it ends.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its result waits in the pending register, with the
//   sequencer held, until the output register frees.
module sequenced_transfer_reassembly (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  str_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output str_pkg::t_out o_out_item
);

    str_pkg::t_cmd cmd;
    str_pkg::t_sts sts;

    // Sequence each item: decode, walk the map, run the CRC, hand over the result
    str_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the buffers, transfer state and result register
    str_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> test/reassembly_checker.sv
`timescale 1ns / 1ps
// Checker for the reassembly block: predicts each result and compares it in order.
module reassembly_checker
    import str_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_in   i_in_item,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_out  i_out_item,
    output int    o_fail_count,
    output int    o_pending
);

    logic [7:0] frame_buffer [MaxBytes];
    bit         frame_seen [MaxFrames];
    bit         xfer_active;
    int         xfer_length;
    int         xfer_frames;
    logic [15:0] xfer_check;
    t_out       expected_results [$];

    function automatic logic [31:0] buffer_crc(input int count);
        logic [31:0] crc;
        crc = CrcInit;
        for (int i = 0; i < count; i++) begin
            crc = crc ^ {24'd0, frame_buffer[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
            end
        end
        return ~crc;
    endfunction

    function automatic t_out predict_result(input t_in it);
        t_out r;
        int   len, frames, seq, plen, off, n;
        bit   found;
        r = '0;
        case (it.opcode)
            OP_BEGIN: begin
                len    = it.transfer_length;
                frames = (len + PayloadBytes - 1) / PayloadBytes;
                if (len == 0 || len > MaxBytes || frames > MaxFrames) begin
                    r.result_code = RES_BEG_REJ;
                end else begin
                    foreach (frame_seen[i]) frame_seen[i] = 0;
                    xfer_length = len;
                    xfer_frames = frames;
                    xfer_check  = it.expected_check;
                    xfer_active = 1;
                    r.result_code = RES_BEG_OK;
                end
            end
            OP_DATA: begin
                seq  = it.frame_number;
                plen = (it.payload_length > PayloadBytes) ? PayloadBytes : it.payload_length;
                r.result_code = RES_IGNORED;
                if (xfer_active && seq < xfer_frames && !frame_seen[seq]) begin
                    off = seq * PayloadBytes;
                    n   = (plen < xfer_length - off) ? plen : xfer_length - off;
                    for (int k = 0; k < n; k++) begin
                        frame_buffer[off + k] = it.payload_bytes[8*k +: 8];
                    end
                    frame_seen[seq] = 1;
                    r.result_code = RES_STORED;
                end
            end
            default: begin
                r.result_code = RES_STATUS;
                if (xfer_active) begin
                    found = 0;
                    for (int i = 0; i < xfer_frames && !found; i++) begin
                        if (!frame_seen[i]) begin
                            r.first_missing = i[9:0];
                            found = 1;
                        end
                    end
                    if (!found) begin
                        r.all_received = 1;
                        r.transfer_complete = (buffer_crc(xfer_length) & 32'hFFFF)
                                              == {16'd0, xfer_check};
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (frame_buffer[i]) frame_buffer[i] = '0;
            foreach (frame_seen[i]) frame_seen[i] = 0;
            xfer_active = 0;
            xfer_length = 0;
            xfer_frames = 0;
            xfer_check  = '0;
            expected_results.delete();
            o_pending   = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_result(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h with no item outstanding", $time, i_out_item);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.result_code != i_out_item.result_code) begin
                        $display("%0t: result_code expected %0d got %0d", $time,
                                 want.result_code, i_out_item.result_code);
                        o_fail_count++;
                    end
                    if (want.all_received != i_out_item.all_received) begin
                        $display("%0t: all_received expected %0d got %0d", $time,
                                 want.all_received, i_out_item.all_received);
                        o_fail_count++;
                    end
                    if (want.first_missing != i_out_item.first_missing) begin
                        $display("%0t: first_missing expected %0d got %0d", $time,
                                 want.first_missing, i_out_item.first_missing);
                        o_fail_count++;
                    end
                    if (want.transfer_complete != i_out_item.transfer_complete) begin
                        $display("%0t: transfer_complete expected %0d got %0d", $time,
                                 want.transfer_complete, i_out_item.transfer_complete);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the sequenced transfer reassembly block.
module tb_top;
    import str_pkg::*;

    // Cycles with no item moving on either channel before the run is abandoned.
    // Covers the reset clearing pass, a full-size status query and the long hold.
    localparam int StallLimit = 20000;
    localparam int ItemTarget = 950;
    localparam int LongHold   = 400;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_item;
    logic out_valid;
    logic out_ready;
    t_out out_item;

    int fail_count;
    int pending;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit hold_req;
    bit big_done;

    sequenced_transfer_reassembly uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    reassembly_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which nothing is accepted on either side.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: stall on its own pattern of modes; a toggle of hold_req
    // holds ready low for a long stretch so the block backs up.
    initial begin
        int  hold_left;
        int  mode;
        int  mode_left;
        bit  hold_seen;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        hold_seen = 0;
        out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LongHold;
            end
            if (hold_left > 0) begin
                out_ready = 0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: out_ready = 1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    default: out_ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Own copy of the reflected CRC-32, used to build transfers that should pass.
    function automatic logic [31:0] crc32_bytes(input logic [7:0] data [$]);
        logic [31:0] c;
        c = 32'hFFFFFFFF;
        foreach (data[i]) begin
            c ^= {24'd0, data[i]};
            repeat (8) c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
        end
        return ~c;
    endfunction

    function automatic t_in make_begin(input int len, input logic [15:0] chk);
        t_in it;
        it = '0;
        it.opcode          = OP_BEGIN;
        it.transfer_length = len[15:0];
        it.expected_check  = chk;
        it.frame_number    = 16'($urandom);
        it.payload_bytes   = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_in make_data(input int seq, input int plen, input logic [47:0] pay);
        t_in it;
        it = '0;
        it.opcode          = OP_DATA;
        it.frame_number    = seq[15:0];
        it.payload_length  = plen[2:0];
        it.payload_bytes   = pay;
        it.transfer_length = 16'($urandom);
        it.expected_check  = 16'($urandom);
        return it;
    endfunction

    function automatic t_in make_query(input t_op op);
        t_in it;
        it = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom});
        it.opcode = op;
        return it;
    endfunction

    // Offer one item and hold it until accepted; the sender works in bursts.
    task automatic send_item(input t_in it);
        if (burst_left == 0) begin
            in_valid = 0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        in_item  = it;
        in_valid = 1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Stray item within a transfer: rejected begin, query, reserved opcode,
    // out-of-range frame or a resend of the last frame number (frame 0 before any).
    task automatic send_noise(input int frames, input int last_seq);
        case ($urandom_range(0, 4))
            0: send_item(make_begin(($urandom_range(0, 3) == 0) ? 0 :
                                    $urandom_range(MaxBytes + 1, 65535), 16'($urandom)));
            1: send_item(make_query(OP_QUERY));
            2: send_item(make_query(OP_RSV));
            3: send_item(make_data($urandom_range(frames, 65535), $urandom_range(0, 7),
                                   48'({$urandom, $urandom})));
            default: send_item(make_data(last_seq, 6, 48'({$urandom, $urandom})));
        endcase
    endtask

    // Send a whole transfer: begin, shuffled frames (in order when large),
    // then a status query. Most carry the right check value.
    task automatic run_transfer(input int len, input bit in_order);
        logic [7:0]  data [$];
        int          order [$];
        int          frames, seq, off, remain, plen, last_seq;
        logic [47:0] pay;
        logic [31:0] crc;
        frames   = (len + PayloadBytes - 1) / PayloadBytes;
        last_seq = 0;
        for (int i = 0; i < len; i++) data.push_back(8'($urandom));
        crc = crc32_bytes(data);
        send_item(make_begin(len, ($urandom_range(0, 3) == 0) ? 16'($urandom) : crc[15:0]));
        for (int i = 0; i < frames; i++) order.push_back(i);
        if (!in_order) order.shuffle();
        foreach (order[j]) begin
            seq = order[j];
            if ($urandom_range(0, 7) == 0) send_noise(frames, last_seq);
            // Query just before the last frame of a large transfer: first
            // missing frame sits at the top of the range.
            if (in_order && j == frames - 1) send_item(make_query(OP_QUERY));
            off    = seq * PayloadBytes;
            remain = len - off;
            pay    = 48'({$urandom, $urandom});
            for (int k = 0; k < PayloadBytes && k < remain; k++) pay[8*k +: 8] = data[off + k];
            if ($urandom_range(0, 15) == 0) begin
                plen = $urandom_range(0, 5);
            end else begin
                plen = $urandom_range((remain < PayloadBytes) ? remain : PayloadBytes, 7);
            end
            send_item(make_data(seq, plen, pay));
            last_seq = seq;
        end
        send_item(make_query(($urandom_range(0, 7) == 0) ? OP_RSV : OP_QUERY));
    endtask

    initial begin
        int len;
        in_valid    = 0;
        in_item     = '0;
        i_rst_n     = 0;
        items_sent  = 0;
        burst_left  = 0;
        hold_req    = 0;
        big_done    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: inactive transfer, bad begins, full-size begin and edges.
        send_item(make_query(OP_QUERY));
        send_item(make_data(0, 6, 48'hFFFF_FFFF_FFFF));
        send_item(make_query(OP_RSV));
        send_item(make_begin(0, 16'hFFFF));
        send_item(make_begin(MaxBytes + 1, 16'h0000));
        send_item(make_begin(65535, 16'hA5A5));
        send_item(make_begin(MaxBytes, 16'h0000));
        send_item(make_query(OP_QUERY));
        send_item(make_data(MaxFrames - 1, 7, 48'hFFFF_FFFF_FFFF));
        send_item(make_data(MaxFrames, 6, 48'h0));
        send_item(make_data(65535, 6, 48'hFFFF_FFFF_FFFF));
        send_item(make_data(MaxFrames - 1, 6, 48'h0));
        send_item(make_data(0, 0, 48'hFFFF_FFFF_FFFF));
        send_item(make_query(OP_QUERY));
        send_item(make_begin(MaxBytes + 1, 16'h1234));
        send_item(make_query(OP_QUERY));
        send_item(make_begin(1, 16'hFFFF));
        send_item(make_data(0, 6, 48'hFFFF_FFFF_FFFF));
        send_item(make_data(1, 6, 48'h0));
        send_item(make_query(OP_QUERY));

        // Pause until every result is back, then hold the receiver off while
        // items keep coming so the block fills and stops taking input.
        drain_results();
        hold_req = ~hold_req;
        run_transfer(13, 0);

        while (items_sent < ItemTarget) begin
            case ($urandom_range(0, 19))
                0, 1: len = $urandom_range(49, 600);
                // Only start a full-size transfer once, and only while it still fits the item budget.
                2: len = (big_done || items_sent + MaxFrames + 20 > ItemTarget) ?
                         $urandom_range(1, 48) : $urandom_range(MaxBytes - 3, MaxBytes);
                default: len = $urandom_range(1, 48);
            endcase
            if (len > 600) begin
                big_done = 1;
                run_transfer(len, 1);
            end else begin
                run_transfer(len, 0);
            end
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        drain_results();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
